FILE: design/umhzd_pkg.sv
// ----------------------------------------------------------------------------
// umhzd_pkg
// Types, codes and the message number step shared by the zero-coded message
// header decoder.
// ----------------------------------------------------------------------------
package umhzd_pkg;

  localparam int unsigned SLOTS = 3;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] CLASS_HIGH   = 2'd0;
  localparam logic [1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [1:0] CLASS_LOW    = 2'd2;
  localparam logic [1:0] CLASS_FIXED  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_EXTRA    = 3'd2;
  localparam logic [2:0] ERR_BAD_NUM  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;
  localparam logic [2:0] ERR_TRUNC    = 3'd5;

  localparam logic [2:0] REG_MAX_BODY   = 3'd0;
  localparam logic [2:0] REG_HIGH_COUNT = 3'd1;
  localparam logic [2:0] REG_MED_COUNT  = 3'd2;
  localparam logic [2:0] REG_LOW_COUNT  = 3'd3;
  localparam logic [2:0] REG_FIXED_BASE = 3'd4;

  localparam logic [2:0] NPOS_NONE = 3'd0;
  localparam logic [2:0] NPOS_ESC1 = 3'd1;
  localparam logic [2:0] NPOS_ESC2 = 3'd2;
  localparam logic [2:0] NPOS_HIGH = 3'd3;
  localparam logic [2:0] NPOS_DONE = 3'd4;

  localparam logic [7:0]  ESC_BYTE        = 8'hff;
  localparam int unsigned ZERO_CODED_BIT  = 7;
  localparam int unsigned BUF_BYTES       = 2048;
  localparam int unsigned HDR_BYTES       = 6;
  localparam int unsigned MIN_PACKET      = 10;
  localparam logic [3:0]  LAST_SHORT_POS  = 4'(MIN_PACKET - 2);
  localparam logic [3:0]  EXTRA_POS       = 4'(HDR_BYTES - 1);
  localparam logic [3:0]  POS_SATURATED   = 4'hf;

  localparam logic [11:0] RST_MAX_BODY   = 12'(BUF_BYTES - HDR_BYTES);
  localparam logic [7:0]  RST_HIGH_COUNT = 8'd255;
  localparam logic [7:0]  RST_MED_COUNT  = 8'd255;
  localparam logic [15:0] RST_LOW_COUNT  = 16'd65535;
  localparam logic [15:0] RST_FIXED_BASE = 16'd65530;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [1:0]  cls;
    logic [15:0] idx;
    logic [7:0]  val;
    logic [7:0]  len;
    logic [2:0]  err;
  } item_t;

  typedef struct packed {
    logic [2:0]  npos;
    logic [7:0]  nhi;
    logic        hdr;
    logic        bad;
    logic [1:0]  cls;
    logic [15:0] idx;
  } feed_t;

  // One expanded byte into the message number decoder.
  function automatic feed_t num_feed(logic [2:0] npos, logic [7:0] hi, logic [7:0] v,
                                     logic [7:0] hcnt, logic [7:0] mcnt,
                                     logic [15:0] lcnt, logic [15:0] fbase);
    feed_t       f;
    logic [15:0] num;
    f      = '0;
    f.nhi  = hi;
    f.npos = npos;
    num    = {hi, v};
    unique case (npos)
      NPOS_NONE: begin
        if (v != ESC_BYTE) begin
          f.npos = NPOS_DONE;
          f.bad  = (v >= hcnt);
          f.hdr  = (v < hcnt);
          f.cls  = CLASS_HIGH;
          f.idx  = {8'h00, v};
        end else begin
          f.npos = NPOS_ESC1;
        end
      end
      NPOS_ESC1: begin
        if (v != ESC_BYTE) begin
          f.npos = NPOS_DONE;
          f.bad  = (v >= mcnt);
          f.hdr  = (v < mcnt);
          f.cls  = CLASS_MEDIUM;
          f.idx  = {8'h00, v};
        end else begin
          f.npos = NPOS_ESC2;
        end
      end
      NPOS_ESC2: begin
        f.nhi  = v;
        f.npos = NPOS_HIGH;
      end
      default: begin
        f.npos = NPOS_DONE;
        if (num >= fbase) begin
          f.hdr = 1'b1;
          f.cls = CLASS_FIXED;
          f.idx = num - fbase;
        end else if (num >= lcnt) begin
          f.bad = 1'b1;
        end else begin
          f.hdr = 1'b1;
          f.cls = CLASS_LOW;
          f.idx = num;
        end
      end
    endcase
    return f;
  endfunction

endpackage

FILE: design/udp_message_header_zero_decoder.sv
// ----------------------------------------------------------------------------
// udp_message_header_zero_decoder
// Parses the fixed header of a message packet, expands zero runs of a
// zero-coded body, decodes the message number and emits header, body run
// and end or error items.
//
//   channel | direction | handshake                  | payload
//   in      | sink      | in_valid_i / in_stall_o    | data_byte_i, packet_end_i
//   out     | source    | out_valid_o / out_stall_i  | item_kind_o .. final_item_o
//   cfg     | sink      | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One packet byte is taken per cycle while the input is not stalled; a byte
// is registered when taken and decoded from that register, and its results
// appear from a three-slot result register. A byte that yields two or three
// items holds the input while the slots drain, one item per unstalled cycle.
// Reset clears all decoder state and loads the register reset values.
// A stall on the output holds the slots and, once they cannot take a new
// byte's results, stalls the input.
// ----------------------------------------------------------------------------
module udp_message_header_zero_decoder #(
  parameter int unsigned BODY_LIMIT_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  flags_value_o,
  output logic [31:0] sequence_number_o,
  output logic [1:0]  message_class_o,
  output logic [15:0] message_index_o,
  output logic [7:0]  body_value_o,
  output logic [7:0]  run_length_o,
  output logic [2:0]  error_code_o,
  output logic        final_item_o
);
  import umhzd_pkg::*;

  localparam int unsigned BW   = BODY_LIMIT_BITS;
  localparam int unsigned SumW = (BW + 1 > 12) ? BW + 1 : 12;
  localparam logic [SumW-1:0] Cap = SumW'((1 << BW) - 1);

  logic [11:0] max_body_q;
  logic [7:0]  high_cnt_q, med_cnt_q;
  logic [15:0] low_cnt_q, fixed_base_q;

  logic [3:0]    pos_q, pos_d;
  logic [7:0]    flags_q, flags_d;
  logic [31:0]   seq_q, seq_d;
  logic          zpend_q, zpend_d;
  logic [2:0]    npos_q, npos_d;
  logic [7:0]    nhi_q, nhi_d;
  logic [BW-1:0] dcnt_q, dcnt_d;
  logic          drop_q, drop_d;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  item_t      slot_q [SLOTS];
  item_t      res_d  [SLOTS];
  logic [1:0] cnt_q;
  logic [1:0] res_n;

  logic accept, pop, proc;

  assign pop        = (cnt_q != 2'd0) && !out_stall_i;
  assign proc       = in_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_stall_o = in_vld_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q   <= RST_MAX_BODY;
      high_cnt_q   <= RST_HIGH_COUNT;
      med_cnt_q    <= RST_MED_COUNT;
      low_cnt_q    <= RST_LOW_COUNT;
      fixed_base_q <= RST_FIXED_BASE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_BODY:   max_body_q   <= cfg_data_i[11:0];
        REG_HIGH_COUNT: high_cnt_q   <= cfg_data_i[7:0];
        REG_MED_COUNT:  med_cnt_q    <= cfg_data_i[7:0];
        REG_LOW_COUNT:  low_cnt_q    <= cfg_data_i;
        REG_FIXED_BASE: fixed_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]      b;
    logic            exp_en;
    logic [7:0]      exp_v;
    logic [7:0]      exp_n;
    logic [7:0]      rem;
    logic [2:0]      err;
    logic [SumW-1:0] lim;
    logic [SumW-1:0] sum;
    feed_t           f1;
    feed_t           f2;
    item_t           it;

    b       = in_byte_q;
    exp_en  = 1'b0;
    exp_v   = 8'h00;
    exp_n   = 8'h00;
    rem     = 8'h00;
    err     = ERR_NONE;
    lim     = '0;
    sum     = '0;
    f1      = '0;
    f2      = '0;
    pos_d   = pos_q;
    flags_d = flags_q;
    seq_d   = seq_q;
    zpend_d = zpend_q;
    npos_d  = npos_q;
    nhi_d   = nhi_q;
    dcnt_d  = dcnt_q;
    drop_d  = drop_q;
    res_n   = 2'd0;
    for (int i = 0; i < SLOTS; i++) begin
      res_d[i] = '0;
    end
    it = '0;

    if (drop_q) begin
      if (in_end_q) begin
        pos_d   = '0;
        zpend_d = 1'b0;
        npos_d  = NPOS_NONE;
        nhi_d   = '0;
        dcnt_d  = '0;
        drop_d  = 1'b0;
      end
    end else if (in_end_q && (pos_q <= LAST_SHORT_POS)) begin
      it.kind = KIND_ERROR;
      it.err  = ERR_SHORT;
      res_d[res_n] = it;
      res_n   = res_n + 2'd1;
      pos_d   = '0;
      zpend_d = 1'b0;
      npos_d  = NPOS_NONE;
      nhi_d   = '0;
      dcnt_d  = '0;
      drop_d  = 1'b0;
    end else begin
      if (pos_q == 4'd0) begin
        flags_d = b;
      end else if (pos_q < EXTRA_POS) begin
        seq_d = {seq_q[23:0], b};
      end else if (pos_q == EXTRA_POS) begin
        if (b != 8'h00) begin
          err = ERR_EXTRA;
        end
      end else if (flags_q[ZERO_CODED_BIT]) begin
        if (zpend_q) begin
          zpend_d = 1'b0;
          exp_en  = 1'b1;
          exp_n   = b;
        end else if (b == 8'h00) begin
          zpend_d = 1'b1;
        end else begin
          exp_en = 1'b1;
          exp_v  = b;
          exp_n  = 8'd1;
        end
      end else begin
        exp_en = 1'b1;
        exp_v  = b;
        exp_n  = 8'd1;
      end

      lim = (SumW'(max_body_q) > Cap) ? Cap : SumW'(max_body_q);
      sum = SumW'(dcnt_q) + SumW'(exp_n);
      f1  = num_feed(npos_q, nhi_q, exp_v, high_cnt_q, med_cnt_q, low_cnt_q, fixed_base_q);
      f2  = num_feed(f1.npos, f1.nhi, exp_v, high_cnt_q, med_cnt_q, low_cnt_q,
                     fixed_base_q);

      if (exp_en) begin
        if (sum > lim) begin
          err = ERR_OVERFLOW;
        end else begin
          dcnt_d = sum[BW-1:0];
          rem    = exp_n;
          if ((rem != 8'h00) && (npos_q != NPOS_DONE)) begin
            rem    = rem - 8'd1;
            npos_d = f1.npos;
            nhi_d  = f1.nhi;
            if (f1.bad) begin
              err = ERR_BAD_NUM;
            end else if (f1.hdr) begin
              it       = '0;
              it.kind  = KIND_HEADER;
              it.flags = flags_q;
              it.seq   = seq_q;
              it.cls   = f1.cls;
              it.idx   = f1.idx;
              res_d[res_n] = it;
              res_n    = res_n + 2'd1;
            end
            if (!f1.bad && (rem != 8'h00) && (f1.npos != NPOS_DONE)) begin
              rem    = rem - 8'd1;
              npos_d = f2.npos;
              nhi_d  = f2.nhi;
              if (f2.bad) begin
                err = ERR_BAD_NUM;
              end else if (f2.hdr) begin
                it       = '0;
                it.kind  = KIND_HEADER;
                it.flags = flags_q;
                it.seq   = seq_q;
                it.cls   = f2.cls;
                it.idx   = f2.idx;
                res_d[res_n] = it;
                res_n    = res_n + 2'd1;
              end
            end
          end
          if ((err == ERR_NONE) && (rem != 8'h00)) begin
            it      = '0;
            it.kind = KIND_BODY;
            it.val  = exp_v;
            it.len  = rem;
            res_d[res_n] = it;
            res_n   = res_n + 2'd1;
          end
        end
      end

      if (err != ERR_NONE) begin
        it      = '0;
        it.kind = KIND_ERROR;
        it.err  = err;
        res_d[res_n] = it;
        res_n   = res_n + 2'd1;
        if (in_end_q) begin
          pos_d   = '0;
          zpend_d = 1'b0;
          npos_d  = NPOS_NONE;
          nhi_d   = '0;
          dcnt_d  = '0;
          drop_d  = 1'b0;
        end else begin
          drop_d = 1'b1;
        end
      end else begin
        pos_d = (pos_q != POS_SATURATED) ? pos_q + 4'd1 : POS_SATURATED;
        if (in_end_q) begin
          it = '0;
          if (zpend_d) begin
            it.kind = KIND_ERROR;
            it.err  = ERR_TRUNC;
          end else if (npos_d != NPOS_DONE) begin
            it.kind = KIND_ERROR;
            it.err  = ERR_BAD_NUM;
          end else begin
            it.kind = KIND_END;
          end
          res_d[res_n] = it;
          res_n   = res_n + 2'd1;
          pos_d   = '0;
          zpend_d = 1'b0;
          npos_d  = NPOS_NONE;
          nhi_d   = '0;
          dcnt_d  = '0;
          drop_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      flags_q  <= '0;
      seq_q    <= '0;
      zpend_q  <= 1'b0;
      npos_q   <= NPOS_NONE;
      nhi_q    <= '0;
      dcnt_q   <= '0;
      drop_q   <= 1'b0;
      in_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (proc) begin
        pos_q   <= pos_d;
        flags_q <= flags_d;
        seq_q   <= seq_d;
        zpend_q <= zpend_d;
        npos_q  <= npos_d;
        nhi_q   <= nhi_d;
        dcnt_q  <= dcnt_d;
        drop_q  <= drop_d;
        cnt_q   <= res_n;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= packet_end_i;
    end
    if (proc) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i] <= res_d[i];
      end
    end else if (pop) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  assign out_valid_o       = (cnt_q != 2'd0);
  assign item_kind_o       = slot_q[0].kind;
  assign flags_value_o     = slot_q[0].flags;
  assign sequence_number_o = slot_q[0].seq;
  assign message_class_o   = slot_q[0].cls;
  assign message_index_o   = slot_q[0].idx;
  assign body_value_o      = slot_q[0].val;
  assign run_length_o      = slot_q[0].len;
  assign error_code_o      = slot_q[0].err;
  assign final_item_o      = slot_q[0].kind[1];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd0 || !out_valid_o)
    else $error("result count and output valid disagree");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && drop_q) |-> (res_n == 2'd0))
    else $error("items emitted while dropping a packet");

  a_error_coded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == KIND_ERROR)) |-> (error_code_o != ERR_NONE))
    else $error("error item without an error code");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_end_q) |=> (pos_q == 4'd0 && !drop_q && !zpend_q))
    else $error("packet state not cleared after packet end");

endmodule
